>>> design/modbus_rtu_response_receiver_defines.svh
// Assertion macros for the Modbus RTU reply receiver.
// Included by the top level; expects signals clk and rst_n in scope.
`ifndef MODBUS_RTU_RESPONSE_RECEIVER_DEFINES_SVH
`define MODBUS_RTU_RESPONSE_RECEIVER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MRX_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define MRX_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/mrtu_rx_pkg.sv
// Shared types, codes and the byte-wide CRC-16 step for the Modbus RTU reply receiver.
// No dependencies.
package mrtu_rx_pkg;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_BYTE  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_WAIT = 2'd1;
    localparam logic [1:0] PH_RECV = 2'd2;

    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_SHORT     = 3'd1;
    localparam logic [2:0] ST_CRC       = 3'd2;
    localparam logic [2:0] ST_EXCEPTION = 3'd3;
    localparam logic [2:0] ST_FRAME     = 3'd4;

    localparam logic RES_BYTE   = 1'b0;
    localparam logic RES_STATUS = 1'b1;

    localparam logic [0:0] REG_TIMEOUT = 1'b0;
    localparam logic [0:0] REG_GAP     = 1'b1;

    localparam logic [15:0] CrcInit      = 16'hFFFF;
    localparam logic [15:0] CrcPoly      = 16'hA001;
    localparam logic [7:0]  ExceptionBit = 8'h80;
    localparam logic [15:0] TimeoutReset = 16'd1000;
    localparam logic [15:0] GapReset     = 16'd4;
    localparam logic [8:0]  MinFrameLen  = 9'd5;
    localparam logic [8:0]  MinEchoLen   = 9'd8;

    typedef struct packed {
        logic [1:0] check_kind;
        logic [6:0] quantity;
        logic [7:0] function_code;
        logic [7:0] slave;
    } armed_t;

    // One byte through the reflected CRC-16, eight shift steps unrolled.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0] data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
        end
        return c;
    endfunction

endpackage

>>> design/modbus_rtu_response_receiver.sv
// Modbus RTU reply receiver: input register, one pass of logic, result register.
// An accepted input word waits in the input register; when it advances, any result
// word it makes is registered in the result register that drives m_tvalid.
// Throughput: one input word per cycle; the input stalls only while a result word waits.
// Reset (rst_n, asynchronous, active low): idle, counters cleared, CRC all ones,
// timeout_ticks = 1000, gap_ticks = 4, both stages empty. Uses mrtu_rx_pkg and defines.
`include "modbus_rtu_response_receiver_defines.svh"

module modbus_rtu_response_receiver
    import mrtu_rx_pkg::*;
#(
    parameter int MAX_FRAME = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    // rx_byte[7:0], expected_slave[15:8], expected_function[23:16],
    // expected_quantity[30:24], check_kind[32:31], zero[39:33]
    input  logic [39:0] s_tdata,
    // opcode[1:0]
    input  logic [1:0]  s_tuser,
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    // byte_index[7:0], data_byte[15:8], status[18:16], frame_length[27:19], zero[31:28]
    output logic [31:0] m_tdata,
    // result_kind[0]
    output logic [0:0]  m_tuser,
    output logic        m_tlast,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [8:0] MaxFrameLen = 9'(MAX_FRAME);

    // Configuration registers.
    logic [15:0] timeout_ticks_reg;
    logic [15:0] gap_ticks_reg;

    // Input stage.
    logic        in_valid_reg;
    logic [1:0]  in_op_reg;
    logic [39:0] in_data_reg;

    // Receiver state.
    logic [1:0]  phase_reg, phase_next;
    logic [15:0] wait_count_reg, wait_count_next;
    logic [15:0] silence_count_reg, silence_count_next;
    logic [8:0]  stored_length_reg, stored_length_next;
    logic [15:0] running_crc_reg, running_crc_next;
    armed_t      armed_reg, armed_next;
    logic [7:0]  header_reg [3];
    logic [7:0]  recent_reg [2];

    // Result stage.
    logic        out_valid_reg;
    logic [31:0] out_data_reg;
    logic        out_kind_reg;
    logic        out_last_reg;

    logic        advance;
    logic        cfg_write;
    logic        store_byte;
    logic        emit;
    logic        emit_kind;
    logic [2:0]  emit_status;
    logic [8:0]  emit_length;
    logic [2:0]  final_status;
    logic [15:0] wait_inc;
    logic [15:0] rx_crc;
    logic [8:0]  need_len;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_GAP) ? {16'h0000, gap_ticks_reg}
                                             : {16'h0000, timeout_ticks_reg};

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    assign wait_inc = wait_count_reg + 16'd1;
    assign rx_crc   = {recent_reg[1], recent_reg[0]};
    assign need_len = MinFrameLen + {1'b0, header_reg[2]};

    // Checks applied when the inter-frame gap closes a reply.
    always_comb
    begin
        final_status = ST_OK;
        if (stored_length_reg < MinFrameLen)
        begin
            final_status = ST_SHORT;
        end
        else if (rx_crc != running_crc_reg)
        begin
            final_status = ST_CRC;
        end
        else if ((header_reg[1] & ExceptionBit) != 8'h00)
        begin
            final_status = ST_EXCEPTION;
        end
        else if (armed_reg.check_kind == KIND_READ)
        begin
            if (header_reg[0] != armed_reg.slave
                || header_reg[1] != armed_reg.function_code
                || header_reg[2] != {armed_reg.quantity, 1'b0}
                || stored_length_reg < need_len)
            begin
                final_status = ST_FRAME;
            end
        end
        else if (armed_reg.check_kind == KIND_WRITE)
        begin
            if (stored_length_reg < MinEchoLen
                || header_reg[0] != armed_reg.slave
                || header_reg[1] != armed_reg.function_code)
            begin
                final_status = ST_FRAME;
            end
        end
    end

    always_comb
    begin
        phase_next         = phase_reg;
        wait_count_next    = wait_count_reg;
        silence_count_next = silence_count_reg;
        stored_length_next = stored_length_reg;
        running_crc_next   = running_crc_reg;
        armed_next         = armed_reg;
        store_byte         = 1'b0;
        emit               = 1'b0;
        emit_kind          = RES_BYTE;
        emit_status        = ST_OK;
        emit_length        = 9'd0;
        case (in_op_reg)
            OP_START:
            begin
                armed_next         = armed_t'(in_data_reg[32:8]);
                phase_next         = PH_WAIT;
                wait_count_next    = 16'd0;
                silence_count_next = 16'd0;
                stored_length_next = 9'd0;
                running_crc_next   = CrcInit;
            end
            OP_BYTE:
            begin
                if (phase_reg != PH_IDLE)
                begin
                    phase_next         = PH_RECV;
                    silence_count_next = 16'd0;
                    if (stored_length_reg < MaxFrameLen)
                    begin
                        store_byte         = 1'b1;
                        emit               = 1'b1;
                        stored_length_next = stored_length_reg + 9'd1;
                        // The CRC trails by two bytes so the received CRC stays out of it.
                        if (stored_length_reg >= 9'd2)
                        begin
                            running_crc_next = crc16_byte(running_crc_reg, recent_reg[0]);
                        end
                    end
                end
            end
            OP_TICK:
            begin
                if (phase_reg == PH_WAIT)
                begin
                    wait_count_next = wait_inc;
                    if (wait_inc >= timeout_ticks_reg)
                    begin
                        phase_next  = PH_IDLE;
                        emit        = 1'b1;
                        emit_kind   = RES_STATUS;
                        emit_status = ST_SHORT;
                    end
                end
                else if (phase_reg == PH_RECV)
                begin
                    if (silence_count_reg >= gap_ticks_reg)
                    begin
                        phase_next  = PH_IDLE;
                        emit        = 1'b1;
                        emit_kind   = RES_STATUS;
                        emit_status = final_status;
                        emit_length = stored_length_reg;
                    end
                    else
                    begin
                        silence_count_next = silence_count_reg + 16'd1;
                    end
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_ticks_reg <= TimeoutReset;
            gap_ticks_reg     <= GapReset;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_GAP)
            begin
                gap_ticks_reg <= pwdata[15:0];
            end
            else
            begin
                timeout_ticks_reg <= pwdata[15:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            phase_reg         <= PH_IDLE;
            wait_count_reg    <= 16'd0;
            silence_count_reg <= 16'd0;
            stored_length_reg <= 9'd0;
            running_crc_reg   <= CrcInit;
            armed_reg         <= '0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                phase_reg         <= phase_next;
                wait_count_reg    <= wait_count_next;
                silence_count_reg <= silence_count_next;
                stored_length_reg <= stored_length_next;
                running_crc_reg   <= running_crc_next;
                armed_reg         <= armed_next;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_op_reg   <= s_tuser;
            in_data_reg <= s_tdata;
        end
        if (advance && store_byte)
        begin
            if (stored_length_reg < 9'd3)
            begin
                header_reg[stored_length_reg[1:0]] <= in_data_reg[7:0];
            end
            recent_reg[0] <= recent_reg[1];
            recent_reg[1] <= in_data_reg[7:0];
        end
        if (advance && emit)
        begin
            out_kind_reg <= emit_kind;
            out_last_reg <= emit_kind;
            if (emit_kind == RES_BYTE)
            begin
                out_data_reg <= {4'h0, 9'd0, ST_OK, in_data_reg[7:0],
                                 stored_length_reg[7:0]};
            end
            else
            begin
                out_data_reg <= {4'h0, emit_length, emit_status, 8'h00, 8'h00};
            end
        end
    end

    `MRX_ASSERT_NOW(a_len_bound, 1'b1, stored_length_reg <= MaxFrameLen,
        "stored frame length exceeds the frame limit")
    `MRX_ASSERT_NEXT(a_status_ends, advance && emit && emit_kind == RES_STATUS,
        phase_reg == PH_IDLE, "receiver not idle after a status word")
    `MRX_ASSERT_NOW(a_stall_holds, !s_tready, in_valid_reg && out_valid_reg,
        "input stalled without a full pipeline")

endmodule
